>>> rtl/core/rbe_pkg.sv
package rbe_pkg;

    localparam int PI_Q24      = 52707179;
    localparam int TWO_PI_Q24  = 105414357;
    localparam int HALF_PI_Q24 = 26353589;

    localparam int CORDIC_STEPS = 25;

    // register stages of the root unit and of the angle unit
    localparam int SQRT_LAT   = 34;
    localparam int CORDIC_LAT = 7 + CORDIC_STEPS;
    // front end: offset, magnitude, square, partial sum
    localparam int FRONT_LAT  = 4;
    localparam int TOTAL_LAT  = FRONT_LAT + SQRT_LAT + CORDIC_LAT;

    localparam int ANGLE_MAX_Q12 = 12868;

    typedef enum logic [1:0] {
        REG_BEACON_X = 2'd0,
        REG_BEACON_Y = 2'd1,
        REG_BEACON_Z = 2'd2
    } t_reg_idx;

    // atan(2^-i) in Q.24 radians
    function automatic logic signed [27:0] atan_step(input int i);
        logic signed [27:0] v;
        case (i)
            0: v = 28'sd13176795;
            1: v = 28'sd7778716;
            2: v = 28'sd4110060;
            3: v = 28'sd2086331;
            4: v = 28'sd1047214;
            5: v = 28'sd524117;
            6: v = 28'sd262123;
            7: v = 28'sd131069;
            default: v = 28'(32'(1) << (24 - i));
        endcase
        return v;
    endfunction

endpackage

>>> rtl/core/rbe_sqrt.sv
module rbe_sqrt (
    input  logic        i_clk,
    input  logic [63:0] i_rad,
    output logic [32:0] o_root
);

    logic [63:0] r_rem  [0:32];
    logic [63:0] r_root [0:32];
    logic [32:0] r_out;

    always_ff @(posedge i_clk) begin
        r_rem[0]  <= i_rad;
        r_root[0] <= '0;
    end

    // one result bit per stage
    for (genvar k = 0; k < 32; k++) begin : g_step
        localparam logic [63:0] StepBit = 64'(1) << (62 - 2 * k);
        logic [63:0] trial;
        assign trial = r_root[k] + StepBit;

        always_ff @(posedge i_clk) begin
            if (r_rem[k] >= trial) begin
                r_rem[k+1]  <= r_rem[k] - trial;
                r_root[k+1] <= (r_root[k] >> 1) + StepBit;
            end else begin
                r_rem[k+1]  <= r_rem[k];
                r_root[k+1] <= r_root[k] >> 1;
            end
        end
    end

    // round half up: remainder above root
    always_ff @(posedge i_clk) begin
        r_out <= 33'(r_root[32][31:0]) + 33'(r_rem[32] > r_root[32]);
    end

    assign o_root = r_out;

endmodule

>>> rtl/core/rbe_atan.sv
module rbe_atan (
    input  logic               i_clk,
    input  logic signed [34:0] i_y,
    input  logic signed [34:0] i_x,
    input  logic signed [15:0] i_off,
    output logic signed [14:0] o_ang
);

    localparam int NSTEP = rbe_pkg::CORDIC_STEPS;

    typedef struct packed {
        logic               xn;
        logic               yn;
        logic               zero;
        logic signed [15:0] off;
    } t_aux;

    logic [38:0] r_ax  [0:2];
    logic [38:0] r_ay  [0:2];
    logic [38:0] r_m   [0:2];
    t_aux        r_aux [0:2];

    logic signed [42:0] r_cx   [0:NSTEP];
    logic signed [42:0] r_cy   [0:NSTEP];
    logic signed [27:0] r_z    [0:NSTEP];
    t_aux               r_caux [0:NSTEP];

    logic signed [30:0] r_d1;
    logic signed [30:0] r_d2;
    logic signed [14:0] r_out;

    logic signed [34:0] abs_x;
    logic signed [34:0] abs_y;
    logic [38:0]        in_ax;
    logic [38:0]        in_ay;

    always_comb begin
        abs_x = (i_x < 0) ? -i_x : i_x;
        abs_y = (i_y < 0) ? -i_y : i_y;
        in_ax = 39'(abs_x[33:0]);
        in_ay = 39'(abs_y[33:0]);
    end

    always_ff @(posedge i_clk) begin
        r_ax[0]      <= in_ax;
        r_ay[0]      <= in_ay;
        r_m[0]       <= (in_ax > in_ay) ? in_ax : in_ay;
        r_aux[0].xn   <= (i_x < 0);
        r_aux[0].yn   <= (i_y < 0);
        r_aux[0].zero <= (in_ax == '0) && (in_ay == '0);
        r_aux[0].off  <= i_off;
    end

    // normalize: larger operand to [2^38, 2^39), two shift steps per stage
    for (genvar j = 0; j < 3; j++) begin : g_norm
        localparam int S1 = 2 ** (5 - 2 * j);
        localparam int S2 = 2 ** (4 - 2 * j);
        logic        c1;
        logic        c2;
        logic [38:0] ax1;
        logic [38:0] ay1;
        logic [38:0] m1;
        logic [38:0] ax2;
        logic [38:0] ay2;
        logic [38:0] m2;

        always_comb begin
            c1  = (r_m[j] >> (39 - S1)) == '0;
            ax1 = c1 ? (r_ax[j] << S1) : r_ax[j];
            ay1 = c1 ? (r_ay[j] << S1) : r_ay[j];
            m1  = c1 ? (r_m[j] << S1) : r_m[j];
            c2  = (m1 >> (39 - S2)) == '0;
            ax2 = c2 ? (ax1 << S2) : ax1;
            ay2 = c2 ? (ay1 << S2) : ay1;
            m2  = c2 ? (m1 << S2) : m1;
        end

        if (j < 2) begin : g_mid
            always_ff @(posedge i_clk) begin
                r_ax[j+1]  <= ax2;
                r_ay[j+1]  <= ay2;
                r_m[j+1]   <= m2;
                r_aux[j+1] <= r_aux[j];
            end
        end else begin : g_last
            always_ff @(posedge i_clk) begin
                r_cx[0]   <= 43'(signed'({1'b0, ax2}));
                r_cy[0]   <= 43'(signed'({1'b0, ay2}));
                r_z[0]    <= '0;
                r_caux[0] <= r_aux[j];
            end
        end
    end

    // vectoring iterations
    for (genvar i = 0; i < NSTEP; i++) begin : g_iter
        localparam logic signed [27:0] Step = rbe_pkg::atan_step(i);
        logic signed [42:0] sx;
        logic signed [42:0] sy;

        assign sx = r_cx[i] >>> i;
        assign sy = r_cy[i] >>> i;

        always_ff @(posedge i_clk) begin
            if (r_cy[i] > 0) begin
                r_cx[i+1] <= r_cx[i] + sy;
                r_cy[i+1] <= r_cy[i] - sx;
                r_z[i+1]  <= r_z[i] + Step;
            end else begin
                r_cx[i+1] <= r_cx[i] - sy;
                r_cy[i+1] <= r_cy[i] + sx;
                r_z[i+1]  <= r_z[i] - Step;
            end
            r_caux[i+1] <= r_caux[i];
        end
    end

    function automatic logic signed [30:0] wrap_step(input logic signed [30:0] d);
        logic signed [30:0] r;
        if (d > 31'(rbe_pkg::PI_Q24)) begin
            r = d - 31'(rbe_pkg::TWO_PI_Q24);
        end else if (d < -31'(rbe_pkg::PI_Q24)) begin
            r = d + 31'(rbe_pkg::TWO_PI_Q24);
        end else begin
            r = d;
        end
        return r;
    endfunction

    logic signed [27:0] quad_a;
    logic signed [30:0] diff;
    logic signed [30:0] wrapped;

    // clamp, quadrant, zero vector, offset
    always_comb begin
        if (r_z[NSTEP] < 0) begin
            quad_a = '0;
        end else if (r_z[NSTEP] > 28'(rbe_pkg::HALF_PI_Q24)) begin
            quad_a = 28'(rbe_pkg::HALF_PI_Q24);
        end else begin
            quad_a = r_z[NSTEP];
        end
        if (r_caux[NSTEP].xn) begin
            quad_a = 28'(rbe_pkg::PI_Q24) - quad_a;
        end
        if (r_caux[NSTEP].yn) begin
            quad_a = -quad_a;
        end
        if (r_caux[NSTEP].zero) begin
            quad_a = '0;
        end
        diff = 31'(quad_a) - (31'(r_caux[NSTEP].off) <<< 12);
    end

    assign wrapped = wrap_step(r_d2);

    always_ff @(posedge i_clk) begin
        r_d1  <= diff;
        r_d2  <= wrap_step(r_d1);
        r_out <= 15'((wrapped + 31'sd2048) >>> 12);
    end

    assign o_ang = r_out;

endmodule

>>> rtl/core/range_bearing_elevation.sv
// Range, bearing and elevation from a body pose to a configured beacon point.
// One pose is taken per clock cycle and busy never rises; the result of each
// pose appears on o_range, o_bearing and o_elevation with o_valid high for a
// single cycle, in order. The receiver cannot stall, so results must be taken
// when the strobe is seen. The pipeline is a four-stage front end, then the
// 34-stage pipelined square root, then the 32-stage CORDIC angle unit.
// Beacon registers are sampled when a pose is taken; write them while no pose
// is in flight.
module range_bearing_elevation (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [31:0] i_pos_z,
    input  logic signed [15:0] i_yaw,
    input  logic signed [15:0] i_pitch,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [31:0]        i_cfg_data,
    output logic               o_valid,
    output logic [31:0]        o_range,
    output logic signed [14:0] o_bearing,
    output logic signed [14:0] o_elevation
);

    localparam int SL = rbe_pkg::SQRT_LAT;
    localparam int CL = rbe_pkg::CORDIC_LAT;

    typedef struct packed {
        logic signed [32:0] dx;
        logic signed [32:0] dy;
        logic signed [32:0] dz;
        logic signed [15:0] yaw;
        logic signed [15:0] pitch;
        logic               sat;
        logic               hc;
    } t_side;

    logic signed [31:0] r_beacon_x;
    logic signed [31:0] r_beacon_y;
    logic signed [31:0] r_beacon_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beacon_x <= '0;
            r_beacon_y <= '0;
            r_beacon_z <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                rbe_pkg::REG_BEACON_X: r_beacon_x <= i_cfg_data;
                rbe_pkg::REG_BEACON_Y: r_beacon_y <= i_cfg_data;
                rbe_pkg::REG_BEACON_Z: r_beacon_z <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign busy = 1'b0;

    logic                 r_v1, r_v2, r_v3, r_v4;
    logic signed [32:0]   r_dx1, r_dy1, r_dz1;
    logic signed [32:0]   r_dx2, r_dy2, r_dz2;
    logic signed [32:0]   r_dx3, r_dy3, r_dz3;
    logic signed [32:0]   r_dx4, r_dy4, r_dz4;
    logic signed [15:0]   r_yaw1, r_yaw2, r_yaw3, r_yaw4;
    logic signed [15:0]   r_pitch1, r_pitch2, r_pitch3, r_pitch4;
    logic [31:0]          r_mx2, r_my2, r_mz2;
    logic [63:0]          r_x2_3, r_y2_3, r_z2_3;
    logic [64:0]          r_h2_4;
    logic [63:0]          r_q4;
    logic [63:0]          r_z2_4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v1 <= start && !busy;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    // front end datapath
    always_ff @(posedge i_clk) begin
        r_dx1    <= 33'(r_beacon_x) - 33'(i_pos_x);
        r_dy1    <= 33'(r_beacon_y) - 33'(i_pos_y);
        r_dz1    <= 33'(r_beacon_z) - 33'(i_pos_z);
        r_yaw1   <= i_yaw;
        r_pitch1 <= i_pitch;

        r_mx2    <= 32'((r_dx1 < 0) ? -r_dx1 : r_dx1);
        r_my2    <= 32'((r_dy1 < 0) ? -r_dy1 : r_dy1);
        r_mz2    <= 32'((r_dz1 < 0) ? -r_dz1 : r_dz1);
        r_dx2    <= r_dx1;
        r_dy2    <= r_dy1;
        r_dz2    <= r_dz1;
        r_yaw2   <= r_yaw1;
        r_pitch2 <= r_pitch1;

        r_x2_3   <= 64'(r_mx2) * 64'(r_mx2);
        r_y2_3   <= 64'(r_my2) * 64'(r_my2);
        r_z2_3   <= 64'(r_mz2) * 64'(r_mz2);
        r_dx3    <= r_dx2;
        r_dy3    <= r_dy2;
        r_dz3    <= r_dz2;
        r_yaw3   <= r_yaw2;
        r_pitch3 <= r_pitch2;

        r_h2_4   <= 65'(r_x2_3) + 65'(r_y2_3);
        r_q4     <= (r_x2_3 >> 2) + (r_y2_3 >> 2);
        r_z2_4   <= r_z2_3;
        r_dx4    <= r_dx3;
        r_dy4    <= r_dy3;
        r_dz4    <= r_dz3;
        r_yaw4   <= r_yaw3;
        r_pitch4 <= r_pitch3;
    end

    logic [65:0] sum_sq;
    logic [63:0] rad_hyp;
    t_side       n_side;

    always_comb begin
        sum_sq       = 66'(r_h2_4) + 66'(r_z2_4);
        rad_hyp      = r_h2_4[64] ? r_q4 : r_h2_4[63:0];
        n_side.dx    = r_dx4;
        n_side.dy    = r_dy4;
        n_side.dz    = r_dz4;
        n_side.yaw   = r_yaw4;
        n_side.pitch = r_pitch4;
        n_side.sat   = (sum_sq[65:64] != 2'b00);
        n_side.hc    = r_h2_4[64];
    end

    logic [32:0] root_rng;
    logic [32:0] root_hyp;

    rbe_sqrt u_sqrt_rng (
        .i_clk  (i_clk),
        .i_rad  (sum_sq[63:0]),
        .o_root (root_rng)
    );

    rbe_sqrt u_sqrt_hyp (
        .i_clk  (i_clk),
        .i_rad  (rad_hyp),
        .o_root (root_hyp)
    );

    // side data held alongside the root units
    t_side r_side [0:SL-1];
    logic  r_sv   [0:SL-1];

    always_ff @(posedge i_clk) begin
        r_side[0] <= n_side;
        for (int k = 1; k < SL; k++) begin
            r_side[k] <= r_side[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < SL; k++) begin
                r_sv[k] <= 1'b0;
            end
        end else begin
            r_sv[0] <= r_v4;
            for (int k = 1; k < SL; k++) begin
                r_sv[k] <= r_sv[k-1];
            end
        end
    end

    logic [31:0]        n_range;
    logic [33:0]        hyp;
    logic signed [34:0] hyp_x;

    always_comb begin
        n_range = (r_side[SL-1].sat || root_rng[32]) ? '1 : root_rng[31:0];
        hyp     = r_side[SL-1].hc ? {root_hyp, 1'b0} : {1'b0, root_hyp};
        hyp_x   = signed'({1'b0, hyp});
    end

    rbe_atan u_atan_brg (
        .i_clk (i_clk),
        .i_y   (35'(r_side[SL-1].dy)),
        .i_x   (35'(r_side[SL-1].dx)),
        .i_off (r_side[SL-1].yaw),
        .o_ang (o_bearing)
    );

    rbe_atan u_atan_elv (
        .i_clk (i_clk),
        .i_y   (35'(r_side[SL-1].dz)),
        .i_x   (hyp_x),
        .i_off (r_side[SL-1].pitch),
        .o_ang (o_elevation)
    );

    logic [31:0] r_rng [0:CL-1];
    logic        r_cv  [0:CL-1];

    always_ff @(posedge i_clk) begin
        r_rng[0] <= n_range;
        for (int k = 1; k < CL; k++) begin
            r_rng[k] <= r_rng[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < CL; k++) begin
                r_cv[k] <= 1'b0;
            end
        end else begin
            r_cv[0] <= r_sv[SL-1];
            for (int k = 1; k < CL; k++) begin
                r_cv[k] <= r_cv[k-1];
            end
        end
    end

    assign o_valid = r_cv[CL-1];
    assign o_range = r_rng[CL-1];

    // every transfer yields a result after the fixed latency
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##(rbe_pkg::TOTAL_LAT) o_valid)
        else $error("result missing after transfer");

    a_bearing_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_bearing >= -15'(rbe_pkg::ANGLE_MAX_Q12))
                 && (o_bearing <= 15'(rbe_pkg::ANGLE_MAX_Q12)))
        else $error("bearing outside wrap interval");

    a_elevation_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_elevation >= -15'(rbe_pkg::ANGLE_MAX_Q12))
                 && (o_elevation <= 15'(rbe_pkg::ANGLE_MAX_Q12)))
        else $error("elevation outside wrap interval");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_v4, SL + CL))
        else $error("result without matching transfer");

endmodule

>>> tb/range_bearing_elevation_tb.sv
module range_bearing_elevation_tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [1:0] {ACT_POSE, ACT_CFG, ACT_DRAIN} t_act;

    typedef struct {
        t_act              act;
        logic signed [31:0] px, py, pz;
        logic signed [15:0] yaw, pitch;
        rbe_pkg::t_reg_idx idx;
        logic [31:0]       data;
    } t_step;

    typedef struct {
        logic [31:0] range;
        logic [14:0] bearing;
        logic [14:0] elevation;
    } t_fix;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic signed [31:0] i_pos_x = '0, i_pos_y = '0, i_pos_z = '0;
    logic signed [15:0] i_yaw = '0, i_pitch = '0;
    logic               i_cfg_we = 1'b0;
    logic [1:0]         i_cfg_idx = '0;
    logic [31:0]        i_cfg_data = '0;
    logic               o_valid;
    logic [31:0]        o_range;
    logic signed [14:0] o_bearing, o_elevation;

    range_bearing_elevation dut (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    t_step       plan_q[$];
    t_fix        fix_q[$];
    logic signed [31:0] bcn[3] = '{0, 0, 0};
    int          mismatches = 0;
    int          poses_sent = 0;
    int          hold = 0;
    int          quiet = 0;
    bit          stim_done = 0;

    function automatic bit [63:0] root_round(bit [63:0] n);
        bit [63:0] rem = n, r = 0, b = 64'd1 << 62;
        while (b > rem) b >>= 2;
        while (b != 0) begin
            if (rem >= r + b) begin
                rem -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        if (n - r * r > r) r++;
        return r;
    endfunction

    function automatic longint angle_q24(longint y, longint x);
        longint ax = (x < 0) ? -x : x;
        longint ay = (y < 0) ? -y : y;
        longint m, cx, cy, sx, sy, z = 0, a;
        m = (ax > ay) ? ax : ay;
        if (m == 0) return 0;
        while (m < (64'sd1 <<< 38)) begin
            m <<= 1; ax <<= 1; ay <<= 1;
        end
        cx = ax;
        cy = ay;
        for (int i = 0; i < rbe_pkg::CORDIC_STEPS; i++) begin
            sx = cx >>> i;
            sy = cy >>> i;
            if (cy > 0) begin
                cx += sy; cy -= sx; z += rbe_pkg::atan_step(i);
            end else begin
                cx -= sy; cy += sx; z -= rbe_pkg::atan_step(i);
            end
        end
        a = z;
        if (a < 0) a = 0;
        if (a > rbe_pkg::HALF_PI_Q24) a = rbe_pkg::HALF_PI_Q24;
        if (x < 0) a = rbe_pkg::PI_Q24 - a;
        if (y < 0) a = -a;
        return a;
    endfunction

    function automatic logic [14:0] wrap_q12(longint ang, logic signed [15:0] off);
        longint d = ang - longint'(off) * 4096;
        while (d > rbe_pkg::PI_Q24) d -= rbe_pkg::TWO_PI_Q24;
        while (d < -rbe_pkg::PI_Q24) d += rbe_pkg::TWO_PI_Q24;
        return 15'((d + 2048) >>> 12);
    endfunction

    function automatic t_fix predict_pose(t_step s);
        t_fix f;
        longint dx = longint'(bcn[0]) - longint'(s.px);
        longint dy = longint'(bcn[1]) - longint'(s.py);
        longint dz = longint'(bcn[2]) - longint'(s.pz);
        bit [63:0] mx = (dx < 0) ? -dx : dx;
        bit [63:0] my = (dy < 0) ? -dy : dy;
        bit [63:0] mz = (dz < 0) ? -dz : dz;
        bit [63:0] x2 = mx * mx, y2 = my * my, z2 = mz * mz, r, hyp;
        bit [64:0] h2 = {1'b0, x2} + {1'b0, y2};
        bit [64:0] s2 = {1'b0, h2[63:0]} + {1'b0, z2};
        if (h2[64] || s2[64]) begin
            f.range = 32'hFFFF_FFFF;
        end else begin
            r = root_round(s2[63:0]);
            f.range = (r > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : r[31:0];
        end
        if (h2[64]) hyp = 2 * root_round((x2 >> 2) + (y2 >> 2));
        else hyp = root_round(h2[63:0]);
        f.bearing = wrap_q12(angle_q24(dy, dx), s.yaw);
        f.elevation = wrap_q12(angle_q24(dz, longint'(hyp)), s.pitch);
        return f;
    endfunction

    task automatic add_pose(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                            logic [15:0] yw, logic [15:0] pt);
        t_step s;
        s.act = ACT_POSE;
        s.px = x; s.py = y; s.pz = z; s.yaw = yw; s.pitch = pt;
        s.idx = rbe_pkg::REG_BEACON_X; s.data = '0;
        plan_q = {plan_q, s};
    endtask

    task automatic add_beacon(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        t_step s;
        s = '{ACT_DRAIN, 0, 0, 0, 0, 0, rbe_pkg::REG_BEACON_X, 0};
        plan_q = {plan_q, s};
        s.act = ACT_CFG;
        s.idx = rbe_pkg::REG_BEACON_X; s.data = x; plan_q = {plan_q, s};
        s.idx = rbe_pkg::REG_BEACON_Y; s.data = y; plan_q = {plan_q, s};
        s.idx = rbe_pkg::REG_BEACON_Z; s.data = z; plan_q = {plan_q, s};
    endtask

    // offsets: mostly near the beacon, some anywhere
    task automatic add_random(int n, logic [31:0] bx, logic [31:0] by, logic [31:0] bz);
        int sh;
        for (int k = 0; k < n; k++) begin
            sh = $urandom_range(31, 0);
            if ($urandom_range(3, 0) == 0)
                add_pose($urandom, $urandom, $urandom, 16'($urandom), 16'($urandom));
            else
                add_pose(bx + ($signed($urandom) >>> sh), by + ($signed($urandom) >>> sh),
                         bz + ($signed($urandom) >>> sh), 16'($urandom), 16'($urandom));
        end
    endtask

    always @(posedge i_clk) begin
        bit cfg_next;
        cfg_next = 1'b0;
        if (i_rst_n) begin
            if (i_cfg_we)
                bcn[i_cfg_idx] <= i_cfg_data;
            if (start && !busy)
                fix_q = {fix_q, predict_pose('{ACT_POSE, i_pos_x, i_pos_y, i_pos_z,
                                               i_yaw, i_pitch, rbe_pkg::REG_BEACON_X, 0})};
            if (!(start && busy)) begin
                if (hold > 0) begin
                    hold <= hold - 1;
                    start <= 1'b0;
                end else if (plan_q.size() == 0) begin
                    start <= 1'b0;
                    stim_done <= 1'b1;
                end else if (plan_q[0].act == ACT_DRAIN) begin
                    start <= 1'b0;
                    if (fix_q.size() == 0 && !(start && !busy)) begin
                        hold <= rbe_pkg::TOTAL_LAT + 4;
                        void'(plan_q.pop_front());
                    end
                end else if (plan_q[0].act == ACT_CFG) begin
                    start <= 1'b0;
                    cfg_next = 1'b1;
                    i_cfg_idx <= plan_q[0].idx;
                    i_cfg_data <= plan_q[0].data;
                    void'(plan_q.pop_front());
                end else if ((poses_sent >= 500 && poses_sent < 700)
                             || $urandom_range(99, 0) >= 38) begin
                    start <= 1'b1;
                    i_pos_x <= plan_q[0].px;
                    i_pos_y <= plan_q[0].py;
                    i_pos_z <= plan_q[0].pz;
                    i_yaw <= plan_q[0].yaw;
                    i_pitch <= plan_q[0].pitch;
                    poses_sent <= poses_sent + 1;
                    void'(plan_q.pop_front());
                end else begin
                    start <= 1'b0;
                end
            end
            i_cfg_we <= cfg_next;
        end
    end

    always @(posedge i_clk) begin
        t_fix e;
        if (i_rst_n && o_valid) begin
            if (fix_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected transfer: range %h bearing %0d elevation %0d",
                             o_range, o_bearing, o_elevation);
            end else begin
                e = fix_q.pop_front();
                if (e.range !== o_range || e.bearing !== o_bearing
                    || e.elevation !== o_elevation) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: range %h/%h bearing %0d/%0d elevation %0d/%0d",
                                 e.range, o_range, $signed(e.bearing), o_bearing,
                                 $signed(e.elevation), o_elevation);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid || !i_rst_n) quiet <= 0;
        else quiet <= quiet + 1;
        if (quiet > 4 * rbe_pkg::TOTAL_LAT + 500) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        // reset beacon at origin: zero vector, axes, field extremes
        add_pose(0, 0, 0, 0, 0);
        add_pose(32'sd65536, 0, 0, 0, 0);
        add_pose(-32'sd65536, 0, 0, 16'h7FFF, 16'h8000);
        add_pose(0, 32'sd1, 0, 16'h8000, 16'h7FFF);
        add_pose(0, 0, -32'sd1, 16'hFFFF, 16'h0001);
        add_pose(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16'h7FFF, 16'h7FFF);
        add_pose(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h8000, 16'h8000);
        add_pose(32'hFFFF_FFFF, 0, 32'h7FFF_FFFF, 16'h3244, 16'hCDBC);
        add_random(280, 0, 0, 0);
        add_beacon(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        // widest offsets: range overflow and wide horizontal distance
        add_pose(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0);
        add_pose(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0);
        add_pose(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0);
        add_pose(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 16'h7FFF, 16'h8000);
        add_pose(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 0, 0);
        add_random(280, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        add_beacon(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        add_pose(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 16'h8000, 16'h7FFF);
        add_pose(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0);
        add_random(280, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        for (int p = 0; p < 2; p++) begin
            automatic logic [31:0] bx = $urandom, by = $urandom, bz = $urandom;
            add_beacon(bx, by, bz);
            add_pose(bx, by, bz, 0, 0);
            add_pose(bx + 32'd5, by, bz, 0, 0);
            add_random(170, bx, by, bz);
        end
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (stim_done && fix_q.size() == 0);
        repeat (rbe_pkg::TOTAL_LAT + 10) @(posedge i_clk);
        if (mismatches == 0 && fix_q.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule

>>> filelist.f
rtl/core/rbe_pkg.sv
rtl/core/rbe_sqrt.sv
rtl/core/rbe_atan.sv
rtl/core/range_bearing_elevation.sv
tb/range_bearing_elevation_tb.sv
